// ===== rtl/kpl_pkg.sv =====
`default_nettype none

package kpl_pkg;

  // keypad geometry, in pixels
  localparam int KeyWidth   = 50;
  localparam int KeyHeight  = 36;
  localparam int KeySpacing = 8;
  localparam int GridLeft   = 20;
  localparam int GridTop    = 20;
  localparam int GridCols   = 3;
  localparam int GridRows   = 4;

  localparam int PinLength  = 4;

  // coordinate width used for the hit test, wide enough for any grid edge
  localparam int PosW = 10;
  // digit counter holds 0..PinLength; entry index addresses the held digits
  localparam int CntW = $clog2(PinLength + 1);
  localparam int IdxW = (PinLength > 1) ? $clog2(PinLength) : 1;

  localparam logic [15:0] PinReset = 16'h1234;

  localparam logic [3:0] KeyClear = 4'd9;
  localparam logic [3:0] KeyZero  = 4'd10;
  localparam logic [3:0] KeyOk    = 4'd11;

  typedef struct packed {
    logic       hit;
    logic [3:0] index;
  } key_t;

  typedef struct packed {
    logic       key_hit;
    logic [3:0] key_index;
    logic [2:0] digits_held;
    logic       login_ok;
    logic       wrong_pin;
  } result_t;

  // BCD digit of the stored PIN for entry position i (0 = first entered)
  function automatic logic [3:0] pin_digit(input logic [15:0] pin, input int i);
    int nib;
    nib = PinLength - 1 - i;
    if (nib >= 4) begin
      return 4'd0;
    end
    return pin[4*nib +: 4];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/kpl_hit_test.sv =====
`default_nettype none

module kpl_hit_test (
  input  wire logic [8:0] touch_x_i,
  input  wire logic [7:0] touch_y_i,
  output kpl_pkg::key_t   key_o
);

  always_comb begin
    logic [kpl_pkg::PosW-1:0] x;
    logic [kpl_pkg::PosW-1:0] y;
    logic [1:0]               col;
    logic [1:0]               row;
    logic                     col_hit;
    logic                     row_hit;
    int                       lo;

    x       = kpl_pkg::PosW'(touch_x_i);
    y       = kpl_pkg::PosW'(touch_y_i);
    col     = 2'd0;
    row     = 2'd0;
    col_hit = 1'b0;
    row_hit = 1'b0;
    lo      = 0;

    // left and top edges inclusive, right and bottom exclusive
    for (int c = 0; c < kpl_pkg::GridCols; c++) begin
      lo = kpl_pkg::GridLeft + c * (kpl_pkg::KeyWidth + kpl_pkg::KeySpacing);
      if (x >= kpl_pkg::PosW'(lo) && x < kpl_pkg::PosW'(lo + kpl_pkg::KeyWidth)) begin
        col_hit = 1'b1;
        col     = 2'(c);
      end
    end

    for (int r = 0; r < kpl_pkg::GridRows; r++) begin
      lo = kpl_pkg::GridTop + r * (kpl_pkg::KeyHeight + kpl_pkg::KeySpacing);
      if (y >= kpl_pkg::PosW'(lo) && y < kpl_pkg::PosW'(lo + kpl_pkg::KeyHeight)) begin
        row_hit = 1'b1;
        row     = 2'(r);
      end
    end

    key_o.hit = col_hit && row_hit;
    if (col_hit && row_hit) begin
      key_o.index = 4'(row) * 4'(kpl_pkg::GridCols) + 4'(col);
    end else begin
      key_o.index = 4'd0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/kpl_core.sv =====
`default_nettype none

module kpl_core (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic [15:0]   cfg_wdata_i,
  input  wire logic          load_i,
  input  wire kpl_pkg::key_t key_i,
  output kpl_pkg::result_t   result_o
);

  logic [15:0]              pin_q;
  logic [kpl_pkg::CntW-1:0] count_q, count_d;
  logic [3:0]               digits_q [kpl_pkg::PinLength];
  logic                     wr_en;
  logic [3:0]               wr_digit;
  logic                     match;
  logic                     ok_press;
  kpl_pkg::result_t         res_q, res_d;

  always_comb begin
    match = (count_q == kpl_pkg::CntW'(kpl_pkg::PinLength));
    for (int i = 0; i < kpl_pkg::PinLength; i++) begin
      if (digits_q[i] != kpl_pkg::pin_digit(pin_q, i)) begin
        match = 1'b0;
      end
    end
  end

  always_comb begin
    count_d   = count_q;
    wr_en     = 1'b0;
    ok_press  = 1'b0;
    wr_digit  = (key_i.index == kpl_pkg::KeyZero) ? 4'd0 : key_i.index + 4'd1;
    res_d.key_hit   = key_i.hit;
    res_d.key_index = key_i.index;
    res_d.login_ok  = 1'b0;
    res_d.wrong_pin = 1'b0;

    if (key_i.hit) begin
      case (key_i.index)
        kpl_pkg::KeyClear: begin
          if (count_q != '0) begin
            count_d = count_q - kpl_pkg::CntW'(1);
          end
        end
        kpl_pkg::KeyOk: begin
          ok_press = 1'b1;
          if (match) begin
            res_d.login_ok = 1'b1;
          end else begin
            res_d.wrong_pin = 1'b1;
            count_d         = '0;
          end
        end
        default: begin
          if (count_q < kpl_pkg::CntW'(kpl_pkg::PinLength)) begin
            wr_en   = 1'b1;
            count_d = count_q + kpl_pkg::CntW'(1);
          end
        end
      endcase
    end

    res_d.digits_held = 3'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pin_q   <= kpl_pkg::PinReset;
      count_q <= '0;
    end else begin
      if (cfg_we_i) begin
        pin_q <= cfg_wdata_i;
      end
      if (load_i) begin
        count_q <= count_d;
      end
    end
  end

  // digit store and result register: no reset needed
  always_ff @(posedge clk_i) begin
    if (load_i && wr_en) begin
      digits_q[count_q[kpl_pkg::IdxW-1:0]] <= wr_digit;
    end
    if (load_i) begin
      res_q <= res_d;
    end
  end

  assign result_o = res_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= kpl_pkg::CntW'(kpl_pkg::PinLength))
    else $error("digit count beyond PIN length");

  a_wrong_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_i && ok_press && !match) |=> (count_q == '0))
    else $error("wrong PIN did not empty the entry");

  a_ok_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_i && res_d.login_ok) |=> (count_q == kpl_pkg::CntW'(kpl_pkg::PinLength)))
    else $error("successful login lost digits");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> !(res_d.login_ok && res_d.wrong_pin))
    else $error("login_ok and wrong_pin both set");

endmodule

`default_nettype wire

// ===== rtl/touch_keypad_pin_lock_unit.sv =====
// Touch keypad PIN lock.
// Input channel (in_valid_i/in_ready_o) carries one touch coordinate per
// request; output channel (out_valid_o/out_ready_i) returns exactly one
// result per touch, in order: key hit, key index, digits held, login_ok and
// wrong_pin.
// A touch is registered on acceptance, hit-tested against the 4x3 key grid
// and applied to the digit entry when the result register can advance,
// where the result is registered and out_valid_o is raised; one touch
// is accepted every cycle while the receiver keeps up.
// When the receiver stalls, the result register holds and the input register
// still takes one more request; in_ready_o then drops until the result moves.
// The PIN register (cfg_we_i/cfg_wdata_i) is written on any edge with the
// enable high; write it only while no request is in flight.
// Reset empties the entry, clears both valid flags and loads PIN 1234.
`default_nettype none

module touch_keypad_pin_lock_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [8:0]  touch_x_i,
  input  wire logic [7:0]  touch_y_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             key_hit_o,
  output logic [3:0]       key_index_o,
  output logic [2:0]       digits_held_o,
  output logic             login_ok_o,
  output logic             wrong_pin_o
);

  logic             s1_valid_q;
  logic             out_valid_q;
  logic [8:0]       x_q;
  logic [7:0]       y_q;
  logic             advance;
  logic             load;
  kpl_pkg::key_t    key;
  kpl_pkg::result_t result;

  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || advance;
  assign load       = s1_valid_q && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      x_q <= touch_x_i;
      y_q <= touch_y_i;
    end
  end

  kpl_hit_test u_hit_test (
    .touch_x_i (x_q),
    .touch_y_i (y_q),
    .key_o     (key)
  );

  kpl_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .load_i      (load),
    .key_i       (key),
    .result_o    (result)
  );

  assign out_valid_o   = out_valid_q;
  assign key_hit_o     = result.key_hit;
  assign key_index_o   = result.key_index;
  assign digits_held_o = result.digits_held;
  assign login_ok_o    = result.login_ok;
  assign wrong_pin_o   = result.wrong_pin;

endmodule

`default_nettype wire
